[sv/sgsm_pkg.sv]
// ----------------------------------------------------------------------------
// sgsm_pkg
// Shared types and constants for the stencil grain set merge block.
// ----------------------------------------------------------------------------
package sgsm_pkg;

   localparam int LIST_DEPTH = 8;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   localparam int GRAIN_W = 16;
   localparam int PHI_W   = 16;
   localparam int PHASE_W = 8;
   localparam int SLOT_W  = 3;
   localparam int LCNT_W  = 4;

   // Broadcast control that every cell of the chain sees in the same cycle.
   typedef struct packed {
      logic               clear;   // transaction accepted with a start mark
      logic               append;  // transaction accepted that stores its grain
      logic [GRAIN_W-1:0] grain;
   } cell_ctl_type;

endpackage

[sv/sgsm_cell.sv]
// ----------------------------------------------------------------------------
// sgsm_cell
// One list position: holds a grain id and an occupied flag, extends the
// duplicate-match chain and the all-occupied chain toward its right neighbor.
// ----------------------------------------------------------------------------
module sgsm_cell
   import sgsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         match_in,
   input  logic         full_in,
   output logic         match_out,
   output logic         full_out
);

   logic               occ_ff;
   logic               occ_in;
   logic [GRAIN_W-1:0] grain_ff;
   logic [GRAIN_W-1:0] grain_in;
   logic               occ_eff;
   logic               take;

   // A start mark empties the list before the transaction is looked at.
   assign occ_eff   = occ_ff && !ctl.clear;
   assign match_out = match_in || (occ_eff && (grain_ff == ctl.grain));
   assign full_out  = full_in && occ_eff;

   // The first free cell takes the appended grain.
   assign take = ctl.append && full_in && !occ_eff;

   always_comb begin
      occ_in   = occ_eff || take;
      grain_in = take ? ctl.grain : grain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      grain_ff <= grain_in;
   end

endmodule

[sv/stencil_grain_set_merge_core.sv]
// ----------------------------------------------------------------------------
// stencil_grain_set_merge_core
// Builds the list of distinct active grains of one stencil point in a row of
// list cells; each append gives one response transaction.
// ----------------------------------------------------------------------------
// Timing: a response appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a response stalls; the cell chain
// finds duplicates in the same cycle; the output register alone sets the pace.
// Reset: synchronous; empties the list and drops any pending response.
// ----------------------------------------------------------------------------
module stencil_grain_set_merge_core
   import sgsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_req,
   input  logic               req_from_center,
   input  logic               req_active,
   input  logic [GRAIN_W-1:0] req_grain_id,
   input  logic [PHI_W-1:0]   req_phi_value,
   input  logic [PHASE_W-1:0] req_phase_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic [GRAIN_W-1:0] rsp_out_grain,
   output logic [PHI_W-1:0]   rsp_out_phi,
   output logic [PHASE_W-1:0] rsp_out_phase,
   output logic [LCNT_W-1:0]  rsp_list_count,
   output logic               rsp_overflow
);

   cell_ctl_type ctl;
   logic [LIST_DEPTH:0] match_chain;
   logic [LIST_DEPTH:0] full_chain;

   logic               accept;
   logic               dup;
   logic               full;
   logic               emit;
   logic [CNT_W-1:0]   cnt_eff;
   logic [CNT_W-1:0]   cnt_next;
   logic [31:0]        slot_wide;
   logic [31:0]        cnt_wide;

   logic [CNT_W-1:0]   cnt_ff,   cnt_in;
   logic               valid_ff, valid_in;
   logic [SLOT_W-1:0]  slot_ff,  slot_in;
   logic [GRAIN_W-1:0] grain_ff, grain_in;
   logic [PHI_W-1:0]   phi_ff,   phi_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LCNT_W-1:0]  lcnt_ff,  lcnt_in;
   logic               ovf_ff,   ovf_in;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign match_chain[0] = 1'b0;
   assign full_chain[0]  = 1'b1;

   genvar i;
   generate
      for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
         sgsm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .match_in  (match_chain[i]),
            .full_in   (full_chain[i]),
            .match_out (match_chain[i+1]),
            .full_out  (full_chain[i+1])
         );
      end
   endgenerate

   assign dup  = match_chain[LIST_DEPTH];
   assign full = full_chain[LIST_DEPTH];

   // Centre entries skip the duplicate check; a full list still answers.
   assign emit = accept && req_active && (req_from_center || !dup);

   always_comb begin
      ctl.clear  = accept && req_start_req;
      ctl.append = emit && !full;
      ctl.grain  = req_grain_id;

      cnt_eff   = req_start_req ? '0 : cnt_ff;
      cnt_next  = ctl.append ? cnt_eff + CNT_W'(1) : cnt_eff;
      slot_wide = full ? 32'd0 : 32'(cnt_eff);
      cnt_wide  = 32'(cnt_next);

      cnt_in   = accept ? cnt_next : cnt_ff;
      valid_in = emit || (valid_ff && rsp_stall);
      slot_in  = emit ? slot_wide[SLOT_W-1:0] : slot_ff;
      grain_in = emit ? req_grain_id : grain_ff;
      phi_in   = emit ? (req_from_center ? req_phi_value : '0) : phi_ff;
      phase_in = emit ? req_phase_code : phase_ff;
      lcnt_in  = emit ? cnt_wide[LCNT_W-1:0] : lcnt_ff;
      ovf_in   = emit ? full : ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      slot_ff  <= slot_in;
      grain_ff <= grain_in;
      phi_ff   <= phi_in;
      phase_ff <= phase_in;
      lcnt_ff  <= lcnt_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_out_grain  = grain_ff;
   assign rsp_out_phi    = phi_ff;
   assign rsp_out_phase  = phase_ff;
   assign rsp_list_count = lcnt_ff;
   assign rsp_overflow   = ovf_ff;

endmodule

[sv/sgsm_checker.sv]
// ----------------------------------------------------------------------------
// sgsm_checker
// Port-level checks for the stencil grain set merge block.
// ----------------------------------------------------------------------------
module sgsm_checker
   import sgsm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_start_req,
   input logic               req_from_center,
   input logic               req_active,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SLOT_W-1:0]  rsp_slot_index,
   input logic [LCNT_W-1:0]  rsp_list_count,
   input logic               rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_ovf_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_slot_index == '0)
      else $error("overflow transaction with nonzero slot");

   a_cnt_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |->
         rsp_list_count[SLOT_W-1:0] == rsp_slot_index + SLOT_W'(1))
      else $error("list count does not follow written slot");

   // A centre entry with a start mark always lands in an empty list.
   a_start_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_start_req && req_from_center && req_active
      |=> rsp_valid && !rsp_overflow && rsp_slot_index == '0
          && rsp_list_count == LCNT_W'(1))
      else $error("start transaction did not restart the list");

endmodule

bind stencil_grain_set_merge_core sgsm_checker u_sgsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_start_req   (req_start_req),
   .req_from_center (req_from_center),
   .req_active      (req_active),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_slot_index  (rsp_slot_index),
   .rsp_list_count  (rsp_list_count),
   .rsp_overflow    (rsp_overflow)
);

[verif/tb_stencil_grain_set_merge_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stencil_grain_set_merge_core
// Self-checking bench for the grain set merge core. Entries go in as request
// transactions with random gaps and receiver stalls; a behavioral copy of the
// distinct-grain list predicts every response transaction and the responses
// are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_stencil_grain_set_merge_core
   import sgsm_pkg::*;
();

   typedef struct packed {
      logic               start_req;
      logic               from_center;
      logic               active;
      logic [GRAIN_W-1:0] grain_id;
      logic [PHI_W-1:0]   phi_value;
      logic [PHASE_W-1:0] phase_code;
   } slot_entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [GRAIN_W-1:0] out_grain;
      logic [PHI_W-1:0]   out_phi;
      logic [PHASE_W-1:0] out_phase;
      logic [LCNT_W-1:0]  list_count;
      logic               overflow;
   } append_result_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_start_req   = 1'b0;
   logic               req_from_center = 1'b0;
   logic               req_active      = 1'b0;
   logic [GRAIN_W-1:0] req_grain_id    = '0;
   logic [PHI_W-1:0]   req_phi_value   = '0;
   logic [PHASE_W-1:0] req_phase_code  = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [SLOT_W-1:0]  rsp_slot_index;
   logic [GRAIN_W-1:0] rsp_out_grain;
   logic [PHI_W-1:0]   rsp_out_phi;
   logic [PHASE_W-1:0] rsp_out_phase;
   logic [LCNT_W-1:0]  rsp_list_count;
   logic               rsp_overflow;

   // Predicted list contents; only the grain ids matter for the duplicate check.
   logic [GRAIN_W-1:0] stored_grain [LIST_DEPTH];
   int                 stored_count = 0;
   append_result_type  pending_appends [$];

   int src_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left    = 0;
   int active_sent  = 0;
   int fail_count   = 0;

   stencil_grain_set_merge_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_req   (req_start_req),
      .req_from_center (req_from_center),
      .req_active      (req_active),
      .req_grain_id    (req_grain_id),
      .req_phi_value   (req_phi_value),
      .req_phase_code  (req_phase_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_out_grain   (rsp_out_grain),
      .rsp_out_phi     (rsp_out_phi),
      .rsp_out_phase   (rsp_out_phase),
      .rsp_list_count  (rsp_list_count),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Applies one accepted entry to the predicted list and queues its response.
   function automatic void merge_entry(input slot_entry_type e);
      logic              dup;
      append_result_type r;
      dup = 1'b0;
      if (e.start_req)
         stored_count = 0;
      if (!e.active)
         return;
      if (!e.from_center)
         for (int i = 0; i < stored_count; i++)
            if (stored_grain[i] == e.grain_id)
               dup = 1'b1;
      if (dup)
         return;
      r.out_grain  = e.grain_id;
      r.out_phi    = e.from_center ? e.phi_value : '0;
      r.out_phase  = e.phase_code;
      r.overflow   = (stored_count >= LIST_DEPTH);
      r.slot_index = '0;
      if (!r.overflow) begin
         r.slot_index = stored_count[SLOT_W-1:0];
         stored_grain[stored_count] = e.grain_id;
         stored_count++;
      end
      r.list_count = stored_count[LCNT_W-1:0];
      pending_appends.push_back(r);
   endfunction

   function automatic slot_entry_type make_entry(input logic start, input logic center,
                                                 input logic act, input logic [15:0] grain,
                                                 input logic [15:0] phi,
                                                 input logic [7:0] phase);
      slot_entry_type e;
      e = '{start, center, act, grain, phi, phase};
      return e;
   endfunction

   function automatic slot_entry_type noise_entry();
      slot_entry_type e;
      e.start_req   = ($urandom_range(7) == 0);
      e.from_center = $urandom_range(1);
      e.active      = $urandom_range(1);
      e.grain_id    = $urandom_range(65535);
      e.phi_value   = $urandom_range(65535);
      e.phase_code  = $urandom_range(255);
      return e;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Called at a clock edge; returns at the edge where the transaction is taken.
   // Valid is left high so that a back-to-back entry keeps the channel busy.
   task automatic send_entry(input slot_entry_type e);
      int gap;
      gap = 0;
      while ($urandom_range(99) < src_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_req   <= e.start_req;
      req_from_center <= e.from_center;
      req_active      <= e.active;
      req_grain_id    <= e.grain_id;
      req_phi_value   <= e.phi_value;
      req_phase_code  <= e.phase_code;
      do
         @(posedge clock);
      while (req_stall);
      merge_entry(e);
      if (e.active)
         active_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_appends.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One stencil point: a start mark, centre slots, then neighbour slots whose
   // grains come from a small pool so that duplicates are common.
   task automatic send_stencil_point();
      int             n_center;
      int             n_neigh;
      int             pool_size;
      int             pool_base;
      slot_entry_type e;
      n_center  = $urandom_range(1, 4);
      n_neigh   = $urandom_range(2, 16);
      pool_size = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 10);
      pool_base = $urandom_range(65535 - pool_size);
      for (int i = 0; i < n_center + n_neigh; i++) begin
         e             = noise_entry();
         e.start_req   = (i == 0);
         e.from_center = (i < n_center);
         e.active      = ($urandom_range(7) != 0);
         e.grain_id    = 16'(pool_base + $urandom_range(pool_size - 1));
         e.phi_value   = ($urandom_range(15) == 0) ? 16'($urandom_range(65535))
                                                   : 16'($urandom_range(32768));
         send_entry(e);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rsp_idle_pct);
      if (hold_left > 0)
         hold_left--;
   end

   always @(posedge clock) begin : check_response
      append_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_appends.size() == 0) begin
            $error("unexpected response transaction: grain %0h", rsp_out_grain);
            fail_count++;
         end else begin
            want = pending_appends.pop_front();
            check_field("slot_index", want.slot_index, rsp_slot_index);
            check_field("out_grain", want.out_grain, rsp_out_grain);
            check_field("out_phi", want.out_phi, rsp_out_phi);
            check_field("out_phase", want.out_phase, rsp_out_phase);
            check_field("list_count", want.list_count, rsp_list_count);
            check_field("overflow", want.overflow, rsp_overflow);
         end
      end
   end

   task automatic test_directed();
      src_idle_pct = 0;
      rsp_idle_pct = 0;
      send_entry(make_entry(1, 1, 1, 16'h0000, 16'h0000, 8'h00));
      send_entry(make_entry(0, 1, 1, 16'hFFFF, 16'h8000, 8'hFF));
      // Centre entries skip the duplicate check; phi above 1.0 passes unchanged.
      send_entry(make_entry(0, 1, 1, 16'hFFFF, 16'hFFFF, 8'h5A));
      send_entry(make_entry(0, 0, 1, 16'hFFFF, 16'h1234, 8'h11));
      send_entry(make_entry(0, 0, 1, 16'h0000, 16'h0001, 8'h22));
      send_entry(make_entry(0, 0, 0, 16'h0101, 16'h0101, 8'h33));
      send_entry(make_entry(0, 0, 1, 16'hA5A5, 16'h7FFF, 8'hC3));
      send_entry(make_entry(0, 0, 1, 16'h0001, 16'h8000, 8'h01));
      send_entry(make_entry(0, 0, 1, 16'h0002, 16'h0000, 8'h02));
      send_entry(make_entry(0, 0, 1, 16'h0004, 16'h4000, 8'h04));
      send_entry(make_entry(0, 0, 1, 16'h0008, 16'h2000, 8'h08));
      // The list is full now: new grains are dropped and flagged.
      send_entry(make_entry(0, 0, 1, 16'h1000, 16'h1000, 8'h10));
      send_entry(make_entry(0, 1, 1, 16'h2000, 16'h4000, 8'h20));
      send_entry(make_entry(0, 0, 1, 16'h0004, 16'h0000, 8'h40));
      // A start mark on an inactive slot still empties the list.
      send_entry(make_entry(1, 0, 0, 16'h3333, 16'h3333, 8'h33));
      send_entry(make_entry(0, 0, 1, 16'h0008, 16'h0008, 8'h80));
      send_entry(make_entry(1, 1, 1, 16'h5555, 16'h8000, 8'hAA));
      send_entry(make_entry(1, 0, 1, 16'h5555, 16'h5555, 8'h55));
      send_entry(make_entry(0, 0, 0, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_entry(make_entry(0, 1, 1, 16'h5555, 16'h0000, 8'h00));
      wait_drained();
   endtask

   // The receiver holds off long enough for the block to back up its input.
   task automatic test_backpressure();
      int target;
      src_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left    = 300;
      target       = active_sent + 60;
      while (active_sent < target)
         send_stencil_point();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int src_pct, input int rcv_pct,
                                      input int n_active);
      int target;
      src_idle_pct = src_pct;
      rsp_idle_pct = rcv_pct;
      target       = active_sent + n_active;
      while (active_sent < target) begin
         if ($urandom_range(99) < 85)
            send_stencil_point();
         else
            repeat ($urandom_range(1, 5)) send_entry(noise_entry());
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_traffic(32, 87, 550);
      test_random_traffic(87, 32, 550);
      test_random_traffic(0, 0, 550);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
